// ----- src/stt_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and sizes for the timer slot table
// no dependencies

package stt_pkg;

   localparam int MaxTimers = 16;
   localparam int IdxW      = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
   localparam int ReqW      = 3;
   localparam int KindW     = 3;
   localparam int TimeW     = 48;
   localparam int DelayW    = 32;
   localparam int HandleW   = 32;
   localparam int CountW    = 5;

   typedef enum logic [ReqW-1:0] {
      REQ_ARM_ONCE     = 3'd0,
      REQ_ARM_PERIODIC = 3'd1,
      REQ_CLEAR        = 3'd2,
      REQ_CLEAR_ALL    = 3'd3,
      REQ_QUERY        = 3'd4,
      REQ_TICK         = 3'd5
   } req_code_type;

   typedef enum logic [KindW-1:0] {
      KIND_ARM       = 3'd0,
      KIND_CLEAR     = 3'd1,
      KIND_QUERY     = 3'd2,
      KIND_FIRE      = 3'd3,
      KIND_TICK_DONE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      HSEL_ZERO,
      HSEL_NEW,
      HSEL_REQ,
      HSEL_SLOT
   } hsel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ARM,
      S_FIND,
      S_CLEAR_ALL,
      S_TICK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     idx_step;
      logic     arm_write;
      logic     slot_free;
      logic     resched;
      logic     wipe_all;
      logic     fired_inc;
      logic     emit;
      kind_type emit_kind;
      hsel_type emit_hsel;
      logic     emit_flag;
      logic     emit_last;
   } cmd_type;

   typedef struct packed {
      logic [ReqW-1:0] in_type;
      logic [ReqW-1:0] req_type;
      logic            dly_zero;
      logic            slot_free;
      logic            slot_match;
      logic            slot_due;
      logic            slot_periodic;
      logic            idx_last;
      logic            out_ok;
   } status_type;

endpackage

// ----- src/software_timer_slot_table_top.sv -----
`timescale 1ns / 1ps
// top level of the timer slot table: controller plus datapath
// depends on stt_pkg, stt_ctrl, stt_datapath
//
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_type, req_now_time, req_delay, req_handle
// rsp     | out       | rsp_valid/rsp_stall | event kind, handle, flag, counts, last
//
// one transaction at a time; the slot scan visits one slot per cycle unless a due result waits
// arm, clear and query stop at the first fitting slot or the last one; tick scans every slot
// unknown request types give no result
// a registered result stage lets the next transaction be taken while a result waits
// rsp_stall on a full result register holds a due result; reset is synchronous, active high

module software_timer_slot_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [stt_pkg::ReqW-1:0]        req_type,
   input  logic [stt_pkg::TimeW-1:0]       req_now_time,
   input  logic [stt_pkg::DelayW-1:0]      req_delay,
   input  logic [stt_pkg::HandleW-1:0]     req_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [stt_pkg::KindW-1:0]       rsp_event_kind,
   output logic [stt_pkg::HandleW-1:0]     rsp_out_handle,
   output logic                            rsp_flag,
   output logic [stt_pkg::CountW-1:0]      rsp_fired_count,
   output logic [stt_pkg::CountW-1:0]      rsp_active_total,
   output logic                            rsp_last
);

   stt_pkg::cmd_type    cmd;
   stt_pkg::status_type sts;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_now_time     (req_now_time),
      .req_delay        (req_delay),
      .req_handle       (req_handle),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_flag         (rsp_flag),
      .rsp_fired_count  (rsp_fired_count),
      .rsp_active_total (rsp_active_total),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// ----- src/stt_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine for the timer slot table
// depends on stt_pkg

module stt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  stt_pkg::status_type sts,
   output stt_pkg::cmd_type    cmd
);

   stt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != stt_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         stt_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
            end
         end
         stt_pkg::S_ARM: begin
            cmd.emit_kind = stt_pkg::KIND_ARM;
            cmd.emit_last = 1'b1;
            if (sts.dly_zero || sts.slot_free || sts.idx_last) begin
               if (sts.out_ok) begin
                  cmd.emit = 1'b1;
                  state_in = stt_pkg::S_IDLE;
                  if (!sts.dly_zero && sts.slot_free) begin
                     cmd.arm_write = 1'b1;
                     cmd.emit_hsel = stt_pkg::HSEL_NEW;
                     cmd.emit_flag = 1'b1;
                  end else begin
                     cmd.emit_hsel = stt_pkg::HSEL_ZERO;
                  end
               end
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         stt_pkg::S_FIND: begin
            cmd.emit_kind = (sts.req_type == stt_pkg::REQ_CLEAR) ?
                            stt_pkg::KIND_CLEAR : stt_pkg::KIND_QUERY;
            cmd.emit_hsel = stt_pkg::HSEL_REQ;
            cmd.emit_flag = sts.slot_match;
            cmd.emit_last = 1'b1;
            if (sts.slot_match || sts.idx_last) begin
               if (sts.out_ok) begin
                  cmd.emit      = 1'b1;
                  cmd.slot_free = sts.slot_match && (sts.req_type == stt_pkg::REQ_CLEAR);
                  state_in      = stt_pkg::S_IDLE;
               end
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         stt_pkg::S_CLEAR_ALL: begin
            cmd.emit_kind = stt_pkg::KIND_CLEAR;
            cmd.emit_hsel = stt_pkg::HSEL_ZERO;
            cmd.emit_last = 1'b1;
            if (sts.out_ok) begin
               cmd.emit     = 1'b1;
               cmd.wipe_all = 1'b1;
               state_in     = stt_pkg::S_IDLE;
            end
         end
         stt_pkg::S_TICK: begin
            cmd.emit_kind = stt_pkg::KIND_FIRE;
            cmd.emit_hsel = stt_pkg::HSEL_SLOT;
            if (!sts.slot_due || sts.out_ok) begin
               if (sts.slot_due) begin
                  cmd.emit      = 1'b1;
                  cmd.fired_inc = 1'b1;
                  cmd.resched   = sts.slot_periodic;
                  cmd.slot_free = !sts.slot_periodic;
               end
               if (sts.idx_last) begin
                  state_in = stt_pkg::S_DONE;
               end else begin
                  cmd.idx_step = 1'b1;
               end
            end
         end
         stt_pkg::S_DONE: begin
            cmd.emit_kind = stt_pkg::KIND_TICK_DONE;
            cmd.emit_hsel = stt_pkg::HSEL_ZERO;
            cmd.emit_last = 1'b1;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = stt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = stt_pkg::S_IDLE;
         end
      endcase

      if (cmd.load) begin
         unique case (sts.in_type) inside
            stt_pkg::REQ_ARM_ONCE, stt_pkg::REQ_ARM_PERIODIC: state_in = stt_pkg::S_ARM;
            stt_pkg::REQ_CLEAR, stt_pkg::REQ_QUERY:           state_in = stt_pkg::S_FIND;
            stt_pkg::REQ_CLEAR_ALL:                           state_in = stt_pkg::S_CLEAR_ALL;
            stt_pkg::REQ_TICK:                                state_in = stt_pkg::S_TICK;
            default:                                          state_in = stt_pkg::S_IDLE;
         endcase
      end
   end

   // results only go out when the output register can take them
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_ok)
      else $error("result emitted while output register is busy");

   // an arm finishes the transaction
   a_arm_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_write |=> state_ff == stt_pkg::S_IDLE)
      else $error("controller kept working after arming a slot");

   // a new transaction is only taken while idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == stt_pkg::S_IDLE) && !cmd.emit)
      else $error("transaction loaded outside idle");

endmodule

// ----- src/stt_datapath.sv -----
`timescale 1ns / 1ps
// slot storage, scan index, counters and result register
// depends on stt_pkg

module stt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [stt_pkg::ReqW-1:0]        req_type,
   input  logic [stt_pkg::TimeW-1:0]       req_now_time,
   input  logic [stt_pkg::DelayW-1:0]      req_delay,
   input  logic [stt_pkg::HandleW-1:0]     req_handle,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [stt_pkg::KindW-1:0]       rsp_event_kind,
   output logic [stt_pkg::HandleW-1:0]     rsp_out_handle,
   output logic                            rsp_flag,
   output logic [stt_pkg::CountW-1:0]      rsp_fired_count,
   output logic [stt_pkg::CountW-1:0]      rsp_active_total,
   output logic                            rsp_last,
   input  stt_pkg::cmd_type                cmd,
   output stt_pkg::status_type             sts
);

   // captured transaction
   logic [stt_pkg::ReqW-1:0]    type_ff;
   logic [stt_pkg::TimeW-1:0]   now_ff;
   logic [stt_pkg::DelayW-1:0]  delay_ff;
   logic [stt_pkg::HandleW-1:0] handle_ff;

   // slot table
   logic [stt_pkg::MaxTimers-1:0] slot_active_ff;
   logic [stt_pkg::MaxTimers-1:0] slot_periodic_ff;
   logic [stt_pkg::HandleW-1:0]   slot_handle_ff   [stt_pkg::MaxTimers];
   logic [stt_pkg::DelayW-1:0]    slot_period_ff   [stt_pkg::MaxTimers];
   logic [stt_pkg::TimeW-1:0]     slot_deadline_ff [stt_pkg::MaxTimers];

   logic [stt_pkg::IdxW-1:0]    idx_ff, idx_in;
   logic [stt_pkg::CountW-1:0]  active_ff, active_in;
   logic [stt_pkg::CountW-1:0]  fired_ff, fired_in;
   logic [stt_pkg::HandleW-1:0] next_handle_ff, next_handle_in, handle_inc;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [stt_pkg::KindW-1:0]   rsp_kind_ff;
   logic [stt_pkg::HandleW-1:0] rsp_handle_ff, rsp_handle_in;
   logic                        rsp_flag_ff;
   logic [stt_pkg::CountW-1:0]  rsp_fired_ff;
   logic [stt_pkg::CountW-1:0]  rsp_active_ff;
   logic                        rsp_last_ff;

   logic                        cur_active;
   logic [stt_pkg::HandleW-1:0] cur_handle;
   logic [stt_pkg::TimeW-1:0]   cur_deadline;
   logic [stt_pkg::DelayW-1:0]  addend;
   logic [stt_pkg::TimeW:0]     sum;
   logic [stt_pkg::TimeW-1:0]   deadline_new;

   assign cur_active   = slot_active_ff[idx_ff];
   assign cur_handle   = slot_handle_ff[idx_ff];
   assign cur_deadline = slot_deadline_ff[idx_ff];

   // saturating deadline add, shared by arm and reschedule
   assign addend       = cmd.arm_write ? delay_ff : slot_period_ff[idx_ff];
   assign sum          = {1'b0, now_ff} + {{(stt_pkg::TimeW + 1 - stt_pkg::DelayW){1'b0}}, addend};
   assign deadline_new = sum[stt_pkg::TimeW] ? '1 : sum[stt_pkg::TimeW-1:0];

   assign handle_inc     = next_handle_ff + stt_pkg::HandleW'(1);
   assign next_handle_in = cmd.arm_write ?
                           ((handle_inc == '0) ? stt_pkg::HandleW'(1) : handle_inc) :
                           next_handle_ff;

   assign sts.in_type       = req_type;
   assign sts.req_type      = type_ff;
   assign sts.dly_zero      = (delay_ff == '0);
   assign sts.slot_free     = !cur_active;
   assign sts.slot_match    = cur_active && (handle_ff != '0) && (cur_handle == handle_ff);
   assign sts.slot_due      = cur_active && (now_ff >= cur_deadline);
   assign sts.slot_periodic = slot_periodic_ff[idx_ff];
   assign sts.idx_last      = (idx_ff == stt_pkg::IdxW'(stt_pkg::MaxTimers - 1));
   assign sts.out_ok        = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + stt_pkg::IdxW'(1);
      end

      active_in = active_ff;
      if (cmd.wipe_all) begin
         active_in = '0;
      end else if (cmd.arm_write) begin
         active_in = active_ff + stt_pkg::CountW'(1);
      end else if (cmd.slot_free) begin
         active_in = active_ff - stt_pkg::CountW'(1);
      end

      fired_in = fired_ff;
      if (cmd.load) begin
         fired_in = '0;
      end else if (cmd.fired_inc) begin
         fired_in = fired_ff + stt_pkg::CountW'(1);
      end

      case (cmd.emit_hsel)
         stt_pkg::HSEL_NEW:  rsp_handle_in = next_handle_ff;
         stt_pkg::HSEL_REQ:  rsp_handle_in = handle_ff;
         stt_pkg::HSEL_SLOT: rsp_handle_in = cur_handle;
         default:            rsp_handle_in = '0;
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff <= '0;
         idx_ff         <= '0;
         active_ff      <= '0;
         fired_ff       <= '0;
         next_handle_ff <= stt_pkg::HandleW'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         active_ff      <= active_in;
         fired_ff       <= fired_in;
         next_handle_ff <= next_handle_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (cmd.wipe_all) begin
            slot_active_ff <= '0;
         end else if (cmd.arm_write) begin
            slot_active_ff[idx_ff] <= 1'b1;
         end else if (cmd.slot_free) begin
            slot_active_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_type;
         now_ff    <= req_now_time;
         delay_ff  <= req_delay;
         handle_ff <= req_handle;
      end
      if (cmd.arm_write) begin
         slot_periodic_ff[idx_ff] <= (type_ff == stt_pkg::REQ_ARM_PERIODIC);
         slot_handle_ff[idx_ff]   <= next_handle_ff;
         slot_period_ff[idx_ff]   <= delay_ff;
      end
      if (cmd.arm_write || cmd.resched) begin
         slot_deadline_ff[idx_ff] <= deadline_new;
      end
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_handle_ff <= rsp_handle_in;
         rsp_flag_ff   <= cmd.emit_flag;
         rsp_fired_ff  <= (cmd.emit_kind == stt_pkg::KIND_TICK_DONE) ? fired_ff : '0;
         rsp_active_ff <= active_in;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_flag         = rsp_flag_ff;
   assign rsp_fired_count  = rsp_fired_ff;
   assign rsp_active_total = rsp_active_ff;
   assign rsp_last         = rsp_last_ff;

   // active count tracks the occupied slots
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      active_ff == stt_pkg::CountW'($countones(slot_active_ff)))
      else $error("active count differs from occupied slots");

   // a slot is only armed when free
   a_arm_free: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_write |-> !cur_active && (delay_ff != '0))
      else $error("arm into an occupied slot or with zero delay");

   // freeing and rescheduling only touch active slots
   a_touch_active: assert property (@(posedge clock) disable iff (reset)
      (cmd.slot_free || cmd.resched) |-> cur_active)
      else $error("free or reschedule of an inactive slot");

endmodule
